[rtl/flow_table_lru_ttl_macros.svh]
// Assertion helpers for the flow table checker.
`ifndef FLOW_TABLE_LRU_TTL_MACROS_SVH
`define FLOW_TABLE_LRU_TTL_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define FTLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same, written as an implication.
`define FTLT_ASSERT_IMP(lbl, pre, post, msg) \
  `FTLT_ASSERT(lbl, (pre) |-> (post), msg)

`endif

[rtl/ftlt_pkg.sv]
// ----------------------------------------------------------------------------
// Flow table package
// Types, codes and sizes shared by the flow table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ftlt_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned StampW   = 48;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_EXPIRED   = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_POS_TIMEOUT = 2'd0,
    CFG_NEG_TIMEOUT = 2'd1,
    CFG_EVICT_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DECIDE,
    S_EVAL,
    S_LRU_DROP,
    S_WRITE,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    SW_MATCH,
    SW_PURGE,
    SW_LRU,
    SW_FREE
  } sweep_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [15:0] fwd_handle;
    logic        negative;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] hit_handle;
    logic        hit_negative;
    logic [8:0]  evicted;
  } out_item_t;

  typedef struct packed {
    logic [103:0]      key;
    logic [15:0]       handle;
    logic              neg;
    logic [31:0]       itime;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

[rtl/flow_table_lru_ttl.sv]
// ----------------------------------------------------------------------------
// Flow table with LRU eviction and timeouts
// IPv4 five-tuple flow cache held in one synchronous memory, swept serially.
// ----------------------------------------------------------------------------
// Usage: an item (lookup, insert, remove or time tick) is taken on the input
// channel when in_valid_i and in_ready_o are high; exactly one result comes
// back on the output channel for each item, in order. Registers are written
// on the configuration channel, which is always ready.
// Sweeps: a tick advances the time without any sweep. Lookup, insert and
// remove first sweep the whole entry memory, one read per cycle over its
// single read port. An insert of a new key into a full table adds one sweep
// for expiry, one sweep per least-recent eviction and a final sweep for the
// lowest free slot. One item is worked on at a time.
// Recency is kept as a use stamp per entry; the least recent entry is the
// valid one with the smallest stamp.
// Reset empties the table (valid bits live in flip-flops), clears time and
// restores the register defaults; no clearing pass runs over the memory.
// A result waits in the output register while the receiver stalls; the next
// item is taken meanwhile, and its result is held back until the register
// frees up. Writes to the memory occur only outside the sweeps, so no write
// touches an entry while a sweep reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_table_lru_ttl #(
  parameter int unsigned CAPACITY = ftlt_pkg::Capacity
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ftlt_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ftlt_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  // Control and state registers.
  ftlt_pkg::state_e  state_q, state_d;
  ftlt_pkg::sweep_e  mode_q, mode_d;
  ftlt_pkg::in_item_t req_q, req_d;
  logic [15:0]       pos_to_q, pos_to_d, neg_to_q, neg_to_d;
  logic [8:0]        evict_q, evict_d;
  logic [31:0]       now_q, now_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ftlt_pkg::StampW-1:0] stamp_q, stamp_d;
  logic [CAPACITY-1:0] valid_q, valid_d;

  // Sweep pipeline.
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              rd_busy_q, rd_busy_d;
  logic              p_vld_q;
  logic [IdxW-1:0]   p_idx_q;
  ftlt_pkg::entry_t  mem_rd_q;

  // Sweep results.
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  ftlt_pkg::entry_t  hit_ent_q, hit_ent_d;
  logic              free_found_q, free_found_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic              best_found_q, best_found_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [ftlt_pkg::StampW-1:0] best_stamp_q, best_stamp_d;
  logic [CntW-1:0]   removed_q, removed_d;

  // Result staging and output register.
  ftlt_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Memory write port.
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  ftlt_pkg::entry_t  wr_data;

  ftlt_pkg::entry_t  mem [CAPACITY];

  // Helper terms.
  logic [103:0]      req_key;
  logic              p_v, p_match, p_exp, sweep_end, hit_exp, more_evict;
  logic [31:0]       p_age, p_lim, h_age, h_lim, rem32;
  logic [8:0]        evicted_sat;
  ftlt_pkg::entry_t  new_ent;

  assign req_key = {req_q.src_addr, req_q.dst_addr, req_q.src_port,
                    req_q.dst_port, req_q.protocol};
  assign p_v       = valid_q[p_idx_q];
  assign p_match   = p_v && (mem_rd_q.key == req_key);
  assign p_age     = now_q - mem_rd_q.itime;
  assign p_lim     = mem_rd_q.neg ? {16'h0, neg_to_q} : {16'h0, pos_to_q};
  assign p_exp     = p_age > p_lim;
  assign h_age     = now_q - hit_ent_q.itime;
  assign h_lim     = hit_ent_q.neg ? {16'h0, neg_to_q} : {16'h0, pos_to_q};
  assign hit_exp   = h_age > h_lim;
  assign sweep_end = p_vld_q && (p_idx_q == LastIdx);
  assign rem32     = 32'(removed_q);
  assign evicted_sat = (rem32 > 32'd511) ? 9'h1FF : rem32[8:0];
  // Keep evicting while below the minimum, or while the table is still full.
  assign more_evict = (count_q != '0) &&
                      ((rem32 < 32'(evict_q)) || (count_q == FullCnt));

  always_comb begin
    new_ent.key    = req_key;
    new_ent.handle = req_q.fwd_handle;
    new_ent.neg    = req_q.negative;
    new_ent.itime  = now_q;
    new_ent.stamp  = stamp_q;
  end

  assign in_ready_o  = (state_q == ftlt_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftlt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.func == ftlt_pkg::FUNC_TICK) ? ftlt_pkg::S_RESP
                                                            : ftlt_pkg::S_SWEEP;
        end
      end
      ftlt_pkg::S_SWEEP: begin
        if (sweep_end) begin
          unique case (mode_q)
            ftlt_pkg::SW_MATCH: state_d = ftlt_pkg::S_DECIDE;
            ftlt_pkg::SW_PURGE: state_d = ftlt_pkg::S_EVAL;
            ftlt_pkg::SW_LRU:   state_d = ftlt_pkg::S_LRU_DROP;
            ftlt_pkg::SW_FREE:  state_d = ftlt_pkg::S_WRITE;
            default:            state_d = ftlt_pkg::S_IDLE;
          endcase
        end
      end
      ftlt_pkg::S_DECIDE: begin
        if (req_q.func == ftlt_pkg::FUNC_INSERT && !hit_q && count_q == FullCnt) begin
          state_d = ftlt_pkg::S_SWEEP;
        end else begin
          state_d = ftlt_pkg::S_RESP;
        end
      end
      ftlt_pkg::S_EVAL:     state_d = ftlt_pkg::S_SWEEP;
      ftlt_pkg::S_LRU_DROP: state_d = ftlt_pkg::S_EVAL;
      ftlt_pkg::S_WRITE:    state_d = ftlt_pkg::S_RESP;
      ftlt_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ftlt_pkg::S_IDLE;
        end
      end
      default: state_d = ftlt_pkg::S_IDLE;
    endcase
  end

  // Datapath and register updates.
  always_comb begin
    mode_d       = mode_q;
    req_d        = req_q;
    pos_to_d     = pos_to_q;
    neg_to_d     = neg_to_q;
    evict_d      = evict_q;
    now_d        = now_q;
    count_d      = count_q;
    stamp_d      = stamp_q;
    valid_d      = valid_q;
    rd_idx_d     = rd_idx_q;
    rd_busy_d    = 1'b0;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_ent_d    = hit_ent_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    removed_d    = removed_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    wr_en        = 1'b0;
    wr_idx       = hit_idx_q;
    wr_data      = new_ent;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ftlt_pkg::CFG_POS_TIMEOUT: pos_to_d = cfg_data_i;
        ftlt_pkg::CFG_NEG_TIMEOUT: neg_to_d = cfg_data_i;
        ftlt_pkg::CFG_EVICT_COUNT: evict_d  = cfg_data_i[8:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ftlt_pkg::S_IDLE: begin
        res_d.status       = ftlt_pkg::ST_MISS;
        res_d.hit_handle   = '0;
        res_d.hit_negative = 1'b0;
        res_d.evicted      = '0;
        if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.func == ftlt_pkg::FUNC_TICK) begin
            now_d = now_q + 32'd1;
          end else begin
            mode_d       = ftlt_pkg::SW_MATCH;
            rd_idx_d     = '0;
            rd_busy_d    = 1'b1;
            hit_d        = 1'b0;
            free_found_d = 1'b0;
          end
        end
      end
      ftlt_pkg::S_SWEEP: begin
        if (rd_busy_q) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          rd_busy_d = (rd_idx_q != LastIdx);
        end
        if (p_vld_q) begin
          unique case (mode_q)
            ftlt_pkg::SW_MATCH: begin
              if (p_match) begin
                hit_d     = 1'b1;
                hit_idx_d = p_idx_q;
                hit_ent_d = mem_rd_q;
              end
              if (!p_v && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = p_idx_q;
              end
            end
            ftlt_pkg::SW_PURGE: begin
              if (p_v && p_exp) begin
                valid_d[p_idx_q] = 1'b0;
                count_d   = count_q - 1'b1;
                removed_d = removed_q + 1'b1;
              end
            end
            ftlt_pkg::SW_LRU: begin
              if (p_v && (!best_found_q || mem_rd_q.stamp < best_stamp_q)) begin
                best_found_d = 1'b1;
                best_idx_d   = p_idx_q;
                best_stamp_d = mem_rd_q.stamp;
              end
            end
            ftlt_pkg::SW_FREE: begin
              if (!p_v && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = p_idx_q;
              end
            end
            default: ;
          endcase
        end
      end
      ftlt_pkg::S_DECIDE: begin
        unique case (req_q.func)
          ftlt_pkg::FUNC_LOOKUP: begin
            if (!hit_q) begin
              res_d.status = ftlt_pkg::ST_MISS;
            end else if (hit_exp) begin
              valid_d[hit_idx_q] = 1'b0;
              count_d      = count_q - 1'b1;
              res_d.status = ftlt_pkg::ST_EXPIRED;
            end else begin
              wr_en              = 1'b1;
              wr_idx             = hit_idx_q;
              wr_data            = hit_ent_q;
              wr_data.stamp      = stamp_q;
              stamp_d            = stamp_q + 1'b1;
              res_d.status       = ftlt_pkg::ST_HIT;
              res_d.hit_handle   = hit_ent_q.handle;
              res_d.hit_negative = hit_ent_q.neg;
            end
          end
          ftlt_pkg::FUNC_INSERT: begin
            res_d.status = ftlt_pkg::ST_INSERTED;
            if (hit_q) begin
              wr_en   = 1'b1;
              wr_idx  = hit_idx_q;
              stamp_d = stamp_q + 1'b1;
            end else if (count_q == FullCnt) begin
              removed_d = '0;
              mode_d    = ftlt_pkg::SW_PURGE;
              rd_idx_d  = '0;
              rd_busy_d = 1'b1;
            end else begin
              wr_en               = 1'b1;
              wr_idx              = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
              count_d             = count_q + 1'b1;
              stamp_d             = stamp_q + 1'b1;
            end
          end
          ftlt_pkg::FUNC_REMOVE: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              count_d      = count_q - 1'b1;
              res_d.status = ftlt_pkg::ST_REMOVED;
            end else begin
              res_d.status = ftlt_pkg::ST_NOT_FOUND;
            end
          end
          default: res_d.status = ftlt_pkg::ST_MISS;
        endcase
      end
      ftlt_pkg::S_EVAL: begin
        rd_idx_d  = '0;
        rd_busy_d = 1'b1;
        if (more_evict) begin
          mode_d       = ftlt_pkg::SW_LRU;
          best_found_d = 1'b0;
        end else begin
          mode_d       = ftlt_pkg::SW_FREE;
          free_found_d = 1'b0;
        end
      end
      ftlt_pkg::S_LRU_DROP: begin
        if (best_found_q) begin
          valid_d[best_idx_q] = 1'b0;
          count_d   = count_q - 1'b1;
          removed_d = removed_q + 1'b1;
        end
      end
      ftlt_pkg::S_WRITE: begin
        wr_en               = 1'b1;
        wr_idx              = free_idx_q;
        valid_d[free_idx_q] = 1'b1;
        count_d             = count_q + 1'b1;
        stamp_d             = stamp_q + 1'b1;
        res_d.status        = ftlt_pkg::ST_INSERTED;
        res_d.evicted       = evicted_sat;
      end
      ftlt_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    mem_rd_q <= mem[rd_idx_q];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rd_idx_q     <= rd_idx_d;
    p_idx_q      <= rd_idx_q;
    hit_idx_q    <= hit_idx_d;
    hit_ent_q    <= hit_ent_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ftlt_pkg::S_IDLE;
      mode_q       <= ftlt_pkg::SW_MATCH;
      pos_to_q     <= 16'd60;
      neg_to_q     <= 16'd5;
      evict_q      <= 9'd4;
      now_q        <= '0;
      count_q      <= '0;
      stamp_q      <= '0;
      valid_q      <= '0;
      rd_busy_q    <= 1'b0;
      p_vld_q      <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      removed_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      pos_to_q     <= pos_to_d;
      neg_to_q     <= neg_to_d;
      evict_q      <= evict_d;
      now_q        <= now_d;
      count_q      <= count_d;
      stamp_q      <= stamp_d;
      valid_q      <= valid_d;
      rd_busy_q    <= rd_busy_d;
      p_vld_q      <= rd_busy_q;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      best_found_q <= best_found_d;
      removed_q    <= removed_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ftlt_checker.sv]
// ----------------------------------------------------------------------------
// Flow table checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flow_table_lru_ttl_macros.svh"

module ftlt_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ftlt_pkg::out_item_t out_data_o
);

  `FTLT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `FTLT_ASSERT_IMP(a_status_legal, out_valid_o, out_data_o.status == ftlt_pkg::ST_HIT || out_data_o.status == ftlt_pkg::ST_MISS || out_data_o.status == ftlt_pkg::ST_EXPIRED || out_data_o.status == ftlt_pkg::ST_INSERTED || out_data_o.status == ftlt_pkg::ST_REMOVED || out_data_o.status == ftlt_pkg::ST_NOT_FOUND, "illegal status")
  `FTLT_ASSERT_IMP(a_handle_on_hit, out_valid_o && out_data_o.status != ftlt_pkg::ST_HIT, out_data_o.hit_handle == 16'h0 && !out_data_o.hit_negative, "handle without hit")
  `FTLT_ASSERT_IMP(a_evict_on_insert, out_valid_o && out_data_o.status != ftlt_pkg::ST_INSERTED, out_data_o.evicted == 9'h0, "eviction count outside insert")

endmodule

bind flow_table_lru_ttl ftlt_checker u_ftlt_checker (.*);

`default_nettype wire

[tb/tb_flow_table_lru_ttl.sv]
// ----------------------------------------------------------------------------
// Flow table testbench
// Drives lookups, inserts, removes and time ticks into the flow table. A
// scoreboard keeps its own copy of the table and predicts every result. A
// directed part covers the corner cases: hits, misses, expiry, duplicate
// keys, full-table cleanup and the eviction limits. After it come
// back-pressure and randomized traffic under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flow_table_lru_ttl;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    Depth       = ftlt_pkg::Capacity;
  localparam int    PoolSize    = 300;
  localparam longint LimitCycles = 6_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  ftlt_pkg::in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  ftlt_pkg::out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  flow_table_lru_ttl #(
    .CAPACITY(ftlt_pkg::Capacity)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 20 ns clock period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Scoreboard copy of the table. Recency is kept as a use sequence number:
  // the least recent valid entry is the one with the smallest number.
  // --------------------------------------------------------------------------
  bit           slot_used   [Depth];
  logic [103:0] slot_key    [Depth];
  logic [15:0]  slot_handle [Depth];
  bit           slot_neg    [Depth];
  logic [31:0]  slot_time   [Depth];
  longint       slot_use    [Depth];
  logic [31:0]  tick_now    = '0;
  int           used_count  = 0;
  longint       use_seq     = 0;
  logic [15:0]  pos_timeout = 16'd60;
  logic [15:0]  neg_timeout = 16'd5;
  logic [8:0]   evict_min   = 9'd4;

  ftlt_pkg::out_item_t pending_results[$];
  int           mismatches   = 0;
  int           items_sent   = 0;
  int           results_seen = 0;
  int           hits_seen    = 0;
  int           expired_seen = 0;
  int           full_inserts = 0;
  longint       cycle_count  = 0;

  // Sender burst state, counted in items, and receiver hold-off, counted in cycles.
  int           burst_left = 0;
  int           hold_left  = 0;

  function automatic logic [103:0] item_key(input ftlt_pkg::in_item_t it);
    return {it.src_addr, it.dst_addr, it.src_port, it.dst_port, it.protocol};
  endfunction

  function automatic int find_flow(input logic [103:0] key);
    for (int i = 0; i < Depth; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit aged_out(input int i);
    logic [31:0] age;
    age = tick_now - slot_time[i];
    return age > (slot_neg[i] ? {16'd0, neg_timeout} : {16'd0, pos_timeout});
  endfunction

  function automatic void drop_flow(input int i);
    slot_used[i] = 1'b0;
    if (used_count > 0) used_count--;
  endfunction

  function automatic void evict_least_recent();
    int victim;
    victim = -1;
    for (int j = 0; j < Depth; j++) begin
      if (slot_used[j] && (victim < 0 || slot_use[j] < slot_use[victim])) victim = j;
    end
    if (victim >= 0) drop_flow(victim);
  endfunction

  // Applies one transfer to the scoreboard table and returns its result.
  function automatic ftlt_pkg::out_item_t flow_table_outcome(input ftlt_pkg::in_item_t it);
    ftlt_pkg::out_item_t res;
    logic [103:0] key;
    int          s;
    int          removed;
    res = '{status: ftlt_pkg::ST_MISS, hit_handle: '0, hit_negative: 1'b0, evicted: '0};
    key = item_key(it);
    case (it.func)
      ftlt_pkg::FUNC_LOOKUP: begin
        s = find_flow(key);
        if (s < 0) begin
          res.status = ftlt_pkg::ST_MISS;
        end else if (aged_out(s)) begin
          drop_flow(s);
          res.status = ftlt_pkg::ST_EXPIRED;
        end else begin
          slot_use[s] = ++use_seq;
          res.status = ftlt_pkg::ST_HIT;
          res.hit_handle = slot_handle[s];
          res.hit_negative = slot_neg[s];
        end
      end
      ftlt_pkg::FUNC_INSERT: begin
        s = find_flow(key);
        if (s < 0) begin
          if (used_count >= Depth) begin
            // Full table: purge expired entries, then evict by recency.
            removed = 0;
            for (int i = 0; i < Depth; i++) begin
              if (slot_used[i] && aged_out(i)) begin
                drop_flow(i);
                removed++;
              end
            end
            while (removed < int'(evict_min) && used_count > 0) begin
              evict_least_recent();
              removed++;
            end
            // A zero eviction limit still has to make room for the new entry.
            if (used_count >= Depth) begin
              evict_least_recent();
              removed++;
            end
            res.evicted = (removed > 511) ? 9'd511 : 9'(removed);
          end
          for (int i = 0; i < Depth; i++) begin
            if (!slot_used[i]) begin
              s = i;
              break;
            end
          end
          slot_used[s] = 1'b1;
          slot_key[s] = key;
          used_count++;
        end
        slot_use[s] = ++use_seq;
        slot_handle[s] = it.fwd_handle;
        slot_neg[s] = it.negative;
        slot_time[s] = tick_now;
        res.status = ftlt_pkg::ST_INSERTED;
      end
      ftlt_pkg::FUNC_REMOVE: begin
        s = find_flow(key);
        if (s < 0) begin
          res.status = ftlt_pkg::ST_NOT_FOUND;
        end else begin
          drop_flow(s);
          res.status = ftlt_pkg::ST_REMOVED;
        end
      end
      default: begin
        tick_now = tick_now + 32'd1;
        res.status = ftlt_pkg::ST_MISS;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input ftlt_pkg::out_item_t exp,
                                 input ftlt_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected status=%0d handle=%h neg=%0b evicted=%0d,",
               $time, what, exp.status, exp.hit_handle, exp.hit_negative, exp.evicted);
      $display("    got status=%0d handle=%h neg=%0b evicted=%0d",
               got.status, got.hit_handle, got.hit_negative, got.evicted);
    end
  endtask

  // Monitor: checks each output transfer, predicts each input transfer and
  // tracks register writes. Everything is sampled at the rising edge.
  always @(posedge clk_i) begin
    ftlt_pkg::out_item_t exp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_data_o);
        end else begin
          exp = pending_results.pop_front();
          if (out_data_o.status !== exp.status || out_data_o.hit_handle !== exp.hit_handle ||
              out_data_o.hit_negative !== exp.hit_negative ||
              out_data_o.evicted !== exp.evicted) begin
            report_mismatch("result mismatch", exp, out_data_o);
          end
          if (exp.status == ftlt_pkg::ST_HIT) hits_seen++;
          if (exp.status == ftlt_pkg::ST_EXPIRED) expired_seen++;
          if (exp.evicted != 0) full_inserts++;
        end
      end
      if (in_valid_i && in_ready_o) pending_results.push_back(flow_table_outcome(in_data_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ftlt_pkg::CFG_POS_TIMEOUT: pos_timeout = cfg_data_i;
          ftlt_pkg::CFG_NEG_TIMEOUT: neg_timeout = cfg_data_i;
          ftlt_pkg::CFG_EVICT_COUNT: evict_min = cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise a stall pattern chosen
  // by bits 10 and 9 of the cycle counter, including stretches with no stalls at all.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      case (cycle_count[10:9])
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  logic [103:0] key_pool[PoolSize];

  function automatic ftlt_pkg::in_item_t make_item(input ftlt_pkg::func_e f,
                                                   input logic [103:0] key,
                                                   input logic [15:0] handle, input bit neg);
    ftlt_pkg::in_item_t it;
    it.func = f;
    {it.src_addr, it.dst_addr, it.src_port, it.dst_port, it.protocol} = key;
    it.fwd_handle = handle;
    it.negative = neg;
    return it;
  endfunction

  // Sends one transfer. Valid stays high across a burst; a gap lowers it.
  task automatic send_item(input ftlt_pkg::in_item_t it);
    int gap;
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic send_op(input ftlt_pkg::func_e f, input logic [103:0] key,
                         input logic [15:0] handle, input bit neg);
    send_item(make_item(f, key, handle, neg));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input ftlt_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] pos_t, input logic [15:0] neg_t,
                            input logic [15:0] evict);
    write_reg(ftlt_pkg::CFG_POS_TIMEOUT, pos_t);
    write_reg(ftlt_pkg::CFG_NEG_TIMEOUT, neg_t);
    write_reg(ftlt_pkg::CFG_EVICT_COUNT, evict);
  endtask

  function automatic logic [103:0] fill_key(input int i);
    return {32'h0A00_0000 + i, $urandom(), 16'(i), 16'hBEEF, 8'd6};
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Lookup, insert and remove on keys at both field extremes, including a
  // duplicate insert and a remove of an absent key.
  task automatic test_basic_ops();
    logic [103:0] ones, zero;
    ones = '1;
    zero = '0;
    send_op(ftlt_pkg::FUNC_LOOKUP, ones, 16'h0000, 1'b0);
    send_op(ftlt_pkg::FUNC_INSERT, ones, 16'hFFFF, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, ones, 16'h0000, 1'b1);
    send_op(ftlt_pkg::FUNC_INSERT, zero, 16'h0000, 1'b1);
    send_op(ftlt_pkg::FUNC_LOOKUP, zero, 16'hFFFF, 1'b0);
    send_op(ftlt_pkg::FUNC_INSERT, ones, 16'h1234, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, ones, 16'h0000, 1'b0);
    send_op(ftlt_pkg::FUNC_REMOVE, zero, 16'h0000, 1'b0);
    send_op(ftlt_pkg::FUNC_REMOVE, zero, 16'h0000, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, zero, 16'h0000, 1'b0);
    send_op(ftlt_pkg::FUNC_TICK, zero, 16'h0000, 1'b0);
    drain();
  endtask

  // Negative and normal entries age out after their own timeouts; a zero
  // timeout expires anything with a nonzero age.
  task automatic test_expiry();
    set_config(16'd60, 16'd5, 16'd4);
    send_op(ftlt_pkg::FUNC_INSERT, key_pool[0], 16'hA001, 1'b1);
    send_op(ftlt_pkg::FUNC_INSERT, key_pool[1], 16'hA002, 1'b0);
    repeat (6) send_op(ftlt_pkg::FUNC_TICK, key_pool[2], 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, key_pool[0], 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, key_pool[1], 16'h0, 1'b0);
    drain();
    write_reg(ftlt_pkg::CFG_POS_TIMEOUT, 16'd0);
    send_op(ftlt_pkg::FUNC_LOOKUP, key_pool[1], 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_INSERT, key_pool[3], 16'hA003, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, key_pool[3], 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_TICK, key_pool[3], 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, key_pool[3], 16'h0, 1'b0);
    drain();
  endtask

  // Fills the table and inserts into it under different eviction limits:
  // the plain limit, cleanup of expired entries, a limit of zero and a limit
  // equal to the table capacity.
  task automatic test_full_table();
    int base;
    int fill;
    set_config(16'd65535, 16'd65535, 16'd4);
    for (int i = 0; i < Depth + 4; i++)
      send_op(ftlt_pkg::FUNC_INSERT, fill_key(i), 16'($urandom()), (i % 8) == 0);
    drain();
    send_op(ftlt_pkg::FUNC_TICK, '0, 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_TICK, '0, 16'h0, 1'b0);
    drain();
    write_reg(ftlt_pkg::CFG_NEG_TIMEOUT, 16'd1);
    send_op(ftlt_pkg::FUNC_INSERT, fill_key(1000), 16'h5555, 1'b0);
    drain();
    // The scoreboard is settled after a drain, so the free count is exact.
    base = 2000;
    fill = Depth - used_count;
    for (int i = 0; i < fill; i++) begin
      send_op(ftlt_pkg::FUNC_INSERT, fill_key(base), 16'($urandom()), 1'b0);
      base++;
    end
    drain();
    write_reg(ftlt_pkg::CFG_EVICT_COUNT, 16'd0);
    send_op(ftlt_pkg::FUNC_INSERT, fill_key(3000), 16'h6666, 1'b0);
    drain();
    write_reg(ftlt_pkg::CFG_EVICT_COUNT, 16'd256);
    send_op(ftlt_pkg::FUNC_INSERT, fill_key(3001), 16'h7777, 1'b1);
    send_op(ftlt_pkg::FUNC_LOOKUP, fill_key(3001), 16'h0, 1'b0);
    send_op(ftlt_pkg::FUNC_LOOKUP, fill_key(5), 16'h0, 1'b0);
    drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block has to stall its input.
  task automatic test_backpressure();
    set_config(16'd60, 16'd5, 16'd4);
    hold_left = 3000;
    burst_left = 20;
    for (int i = 0; i < 14; i++)
      send_op((i % 3 == 0) ? ftlt_pkg::FUNC_INSERT : ftlt_pkg::FUNC_LOOKUP, key_pool[i % 5],
              16'($urandom()), 1'($urandom_range(0, 1)));
    drain();
  endtask

  // Random traffic over a key pool, one phase per register setting.
  task automatic test_random_traffic();
    logic [15:0] pos_list[5]   = '{16'd1, 16'd20, 16'd65535, 16'd50, 16'd7};
    logic [15:0] neg_list[5]   = '{16'd1, 16'd3, 16'd65535, 16'd10, 16'd2};
    logic [15:0] evict_list[5] = '{16'd1, 16'd8, 16'd2, 16'd3, 16'd256};
    int          pool_list[5]  = '{16, 48, 64, 200, 280};
    int          ins_list[5]   = '{35, 35, 40, 45, 80};
    int          r;
    ftlt_pkg::func_e f;
    logic [103:0] key;
    for (int p = 0; p < 5; p++) begin
      set_config(pos_list[p], neg_list[p], evict_list[p]);
      for (int n = 0; n < 170; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_list[p]) f = ftlt_pkg::FUNC_INSERT;
        else if (r < ins_list[p] + 30) f = ftlt_pkg::FUNC_LOOKUP;
        else if (r < ins_list[p] + 42) f = ftlt_pkg::FUNC_REMOVE;
        else f = ftlt_pkg::FUNC_TICK;
        if ($urandom_range(0, 19) == 0) key = {$urandom(), $urandom(), $urandom(), $urandom()};
        else key = key_pool[$urandom_range(0, pool_list[p] - 1)];
        send_op(f, key, 16'($urandom()), 1'($urandom_range(0, 1)));
      end
      drain();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= ftlt_pkg::CFG_POS_TIMEOUT;
    cfg_data_i <= '0;
    for (int i = 0; i < PoolSize; i++)
      key_pool[i] = {$urandom(), $urandom(), $urandom(), $urandom()};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_expiry();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d items: %0d hits, %0d expired lookups, %0d inserts into a full table.",
             items_sent, hits_seen, expired_seen, full_inserts);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[flow_table_lru_ttl.f]
+incdir+rtl
rtl/ftlt_pkg.sv
rtl/flow_table_lru_ttl.sv
rtl/ftlt_checker.sv
tb/tb_flow_table_lru_ttl.sv
